@@ sv/rfes_pkg.sv @@
// rfes_pkg: shared constants for the rf envelope statistics block
// field widths, register map and fixed-point scaling; no dependencies
package rfes_pkg;

    localparam int MAG_W      = 16;   // sample magnitude, unsigned q1.15
    localparam int SQ_W       = 32;   // squared magnitude, q2.30
    localparam int FRAC_W     = 16;   // fraction results, q1.15
    localparam int FRAC_SHIFT = 15;   // one in q1.15 is 1 << 15
    localparam int OUT_DATA_W = 80;   // abs_mean, square_mean, two fractions

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 1'b0;
    localparam logic [MAG_W-1:0]     THRESHOLD_RESET = 16'd7327;

endpackage

@@ sv/rf_envelope_statistics.sv @@
// rf_envelope_statistics: top level, per-pulse statistics of an rf envelope stream
// instantiates rfes_front, rfes_queue, rfes_divider; uses rfes_pkg
//
// channel   | dir | handshake                 | payload
// ----------+-----+---------------------------+-------------------------------------------
// sample in | in  | s_tvalid / s_tready       | s_tdata[15:0] magnitude, s_tlast end of pulse
// result    | out | m_tvalid / m_tready       | m_tdata abs/square mean, fractions; m_tuser
// config    | in  | psel, penable, pwrite     | paddr, pwdata, prdata (threshold at 0x0)
//
// samples are taken one per cycle while s_tready is high; the front end accumulates and
// hands a record per pulse to a two-entry queue. the back end divides four values by the
// sample count at one quotient bit per cycle, in 32 + clog2(MAX_SAMPLES) steps between a
// load and a finish per pulse. s_tready drops only while both queue entries are taken.
// a finished result waits in an output register while the next pulse divides.
// reset clears all accumulators and loads the threshold with 7327 (0.2236 in q1.15).
module rf_envelope_statistics
    import rfes_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [MAG_W-1:0]      s_tdata,   // [15:0] sample_magnitude
    input  logic                  s_tlast,   // last_sample
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] abs_mean, [47:16] square_mean, [63:48] duty_fraction,
    // [79:64] longest_run_fraction
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,   // [0] overflow
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // counters must hold MAX_SAMPLES itself
    localparam int LOG_MAX = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int MSUM_W  = MAG_W + LOG_MAX;
    localparam int SSUM_W  = SQ_W + LOG_MAX;
    localparam int REC_W   = MSUM_W + SSUM_W + 3 * CNT_W + 1;

    logic [MAG_W-1:0]     threshold_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    // front to queue
    logic              fr_valid;
    logic              fr_ready;
    logic [MSUM_W-1:0] fr_msum;
    logic [SSUM_W-1:0] fr_ssum;
    logic [CNT_W-1:0]  fr_duty;
    logic [CNT_W-1:0]  fr_longest;
    logic [CNT_W-1:0]  fr_count;
    logic              fr_ovf;
    logic [REC_W-1:0]  fr_rec;

    // queue to divider
    logic              q_valid;
    logic              q_ready;
    logic [REC_W-1:0]  q_rec;

    // config register; pready always high so the access cycle completes at once
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (cfg_write && reg_idx == REG_THRESHOLD)
            threshold_reg <= pwdata[MAG_W-1:0];
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    rfes_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .MSUM_W      (MSUM_W),
        .SSUM_W      (SSUM_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .threshold   (threshold_reg),
        .smp_valid   (s_tvalid),
        .smp_ready   (s_tready),
        .smp_mag     (s_tdata),
        .smp_last    (s_tlast),
        .rec_valid   (fr_valid),
        .rec_ready   (fr_ready),
        .rec_msum    (fr_msum),
        .rec_ssum    (fr_ssum),
        .rec_duty    (fr_duty),
        .rec_longest (fr_longest),
        .rec_count   (fr_count),
        .rec_ovf     (fr_ovf)
    );

    assign fr_rec = {fr_ovf, fr_count, fr_longest, fr_duty, fr_ssum, fr_msum};

    rfes_queue #(
        .W (REC_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  (fr_rec),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_rec)
    );

    rfes_divider #(
        .CNT_W  (CNT_W),
        .MSUM_W (MSUM_W),
        .SSUM_W (SSUM_W)
    ) u_divider (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec_valid   (q_valid),
        .rec_ready   (q_ready),
        .rec_msum    (q_rec[MSUM_W-1:0]),
        .rec_ssum    (q_rec[MSUM_W +: SSUM_W]),
        .rec_duty    (q_rec[MSUM_W+SSUM_W +: CNT_W]),
        .rec_longest (q_rec[MSUM_W+SSUM_W+CNT_W +: CNT_W]),
        .rec_count   (q_rec[MSUM_W+SSUM_W+2*CNT_W +: CNT_W]),
        .rec_ovf     (q_rec[REC_W-1]),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_data    (m_tdata),
        .res_ovf     (m_tuser)
    );

endmodule

@@ sv/rfes_front.sv @@
// rfes_front: per-pulse accumulators fed by the sample stream
// emits one pulse record on the last sample; uses rfes_pkg
module rfes_front
    import rfes_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096,
    parameter int CNT_W       = 13,
    parameter int MSUM_W      = 28,
    parameter int SSUM_W      = 44
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MAG_W-1:0]  threshold,
    input  logic              smp_valid,
    output logic              smp_ready,
    input  logic [MAG_W-1:0]  smp_mag,
    input  logic              smp_last,
    output logic              rec_valid,
    input  logic              rec_ready,
    output logic [MSUM_W-1:0] rec_msum,
    output logic [SSUM_W-1:0] rec_ssum,
    output logic [CNT_W-1:0]  rec_duty,
    output logic [CNT_W-1:0]  rec_longest,
    output logic [CNT_W-1:0]  rec_count,
    output logic              rec_ovf
);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MSUM_W-1:0] msum_reg, msum_next;
    logic [SSUM_W-1:0] ssum_reg, ssum_next;
    logic [CNT_W-1:0]  above_reg, above_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  lrun_reg, lrun_next;
    logic              ovf_reg, ovf_next;
    logic [SQ_W-1:0]   sq;
    logic              full;
    logic [CNT_W-1:0]  longest;
    logic              accept;

    assign sq        = SQ_W'(smp_mag) * SQ_W'(smp_mag);
    assign full      = (cnt_reg == CNT_W'(MAX_SAMPLES));
    assign smp_ready = rec_ready;
    assign accept    = smp_valid && smp_ready;

    always_comb
    begin
        cnt_next   = cnt_reg;
        msum_next  = msum_reg;
        ssum_next  = ssum_reg;
        above_next = above_reg;
        run_next   = run_reg;
        lrun_next  = lrun_reg;
        ovf_next   = ovf_reg;
        if (!full)
        begin
            cnt_next  = cnt_reg + 1'b1;
            msum_next = msum_reg + MSUM_W'(smp_mag);
            ssum_next = ssum_reg + SSUM_W'(sq);
            if (smp_mag > threshold)
            begin
                above_next = above_reg + 1'b1;
                run_next   = run_reg + 1'b1;
            end
            else
            begin
                if (run_reg > lrun_reg)
                    lrun_next = run_reg;
                run_next = '0;
            end
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    // the open run counts toward the longest one at pulse end
    assign longest     = (run_next > lrun_next) ? run_next : lrun_next;
    assign rec_duty    = (above_next < longest) ? longest : above_next;
    assign rec_longest = longest;
    assign rec_msum    = msum_next;
    assign rec_ssum    = ssum_next;
    assign rec_count   = cnt_next;
    assign rec_ovf     = ovf_next;
    assign rec_valid   = smp_valid && smp_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            msum_reg  <= '0;
            ssum_reg  <= '0;
            above_reg <= '0;
            run_reg   <= '0;
            lrun_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (smp_last)
            begin
                cnt_reg   <= '0;
                msum_reg  <= '0;
                ssum_reg  <= '0;
                above_reg <= '0;
                run_reg   <= '0;
                lrun_reg  <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                cnt_reg   <= cnt_next;
                msum_reg  <= msum_next;
                ssum_reg  <= ssum_next;
                above_reg <= above_next;
                run_reg   <= run_next;
                lrun_reg  <= lrun_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond limit");

endmodule

@@ sv/rfes_queue.sv @@
// rfes_queue: two-entry queue of pulse records between front and divider
// depends on nothing but its width parameter
module rfes_queue #(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         push;
    logic         pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

@@ sv/rfes_divider.sv @@
// rfes_divider: four restoring dividers sharing one step counter, plus result register
// one quotient bit per lane per cycle; uses rfes_pkg
module rfes_divider
    import rfes_pkg::*;
#(
    parameter int CNT_W  = 13,
    parameter int MSUM_W = 28,
    parameter int SSUM_W = 44
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rec_valid,
    output logic                  rec_ready,
    input  logic [MSUM_W-1:0]     rec_msum,
    input  logic [SSUM_W-1:0]     rec_ssum,
    input  logic [CNT_W-1:0]      rec_duty,
    input  logic [CNT_W-1:0]      rec_longest,
    input  logic [CNT_W-1:0]      rec_count,
    input  logic                  rec_ovf,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic [OUT_DATA_W-1:0] res_data,
    output logic                  res_ovf
);

    localparam int LANES  = 4;
    localparam int DIV_W  = SSUM_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  dvd_reg  [LANES];
    logic [CNT_W-1:0]  rem_reg  [LANES];
    logic [SQ_W-1:0]   quot_reg [LANES];
    logic [DIV_W-1:0]  dvd_load [LANES];
    logic [CNT_W-1:0]  divisor_reg;
    logic              ovf_reg;
    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic              out_ovf_reg;
    logic              load;
    logic              finish;

    assign done      = busy_reg && (step_reg == STEP_W'(DIV_W));
    assign finish    = done && (!out_valid_reg || res_ready);
    assign rec_ready = !busy_reg;
    assign load      = rec_valid && rec_ready;

    // fractions are scaled by one in q1.15 before dividing
    assign dvd_load[0] = DIV_W'(rec_msum);
    assign dvd_load[1] = rec_ssum;
    assign dvd_load[2] = DIV_W'({rec_duty, {FRAC_SHIFT{1'b0}}});
    assign dvd_load[3] = DIV_W'({rec_longest, {FRAC_SHIFT{1'b0}}});

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        logic [CNT_W:0] trial;
        logic           fits;

        assign trial = {rem_reg[i], dvd_reg[i][DIV_W-1]};
        assign fits  = (trial >= {1'b0, divisor_reg});

        always_ff @(posedge clk)
        begin
            if (load)
            begin
                dvd_reg[i]  <= dvd_load[i];
                rem_reg[i]  <= '0;
                quot_reg[i] <= '0;
            end
            else if (busy_reg && !done)
            begin
                dvd_reg[i]  <= {dvd_reg[i][DIV_W-2:0], 1'b0};
                rem_reg[i]  <= fits ? CNT_W'(trial - {1'b0, divisor_reg}) : CNT_W'(trial);
                quot_reg[i] <= {quot_reg[i][SQ_W-2:0], fits};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            divisor_reg <= rec_count;
            ovf_reg     <= rec_ovf;
        end
        if (finish)
        begin
            out_data_reg <= {quot_reg[3][FRAC_W-1:0], quot_reg[2][FRAC_W-1:0],
                             quot_reg[1], quot_reg[0][MAG_W-1:0]};
            out_ovf_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && !done)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (finish)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;
    assign res_ovf   = out_ovf_reg;

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(DIV_W))
        else $error("divider step beyond dividend width");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_reg != '0) |-> (rem_reg[0] < divisor_reg))
        else $error("partial remainder not below divisor");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done))
        else $error("result without finished division");

endmodule

@@ test/testbench.sv @@
// testbench: self-checking bench for rf_envelope_statistics, sample stream in, pulse stats out
// depends on rfes_pkg and the block rtl; predicts each pulse result with its own accumulators
// runs directed pulses and random pulses under several thresholds, with a long receiver hold-off
module testbench
    import rfes_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PULSE_LIMIT    = 4096;   // MAX_SAMPLES of the block
    localparam int RX_HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int DRAIN_CYCLES   = 60;     // a little over one divide pass
    localparam int SHOW_LIMIT     = 10;     // mismatches printed in full
    localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = APB_ADDR_W'({REG_THRESHOLD, 2'b00});
    localparam logic [63:0] FRAC_ONE = 64'd1 << FRAC_SHIFT;

    // one sample transfer on the input stream
    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             last;
    } sample_t;

    // one pulse result as carried by m_tdata / m_tuser
    typedef struct packed {
        logic [FRAC_W-1:0] abs_mean;
        logic [SQ_W-1:0]   square_mean;
        logic [FRAC_W-1:0] duty_fraction;
        logic [FRAC_W-1:0] longest_run_fraction;
        logic              overflow;
    } pulse_stats_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [MAG_W-1:0]      s_tdata = '0;   // [15:0] sample_magnitude
    logic                  s_tlast = 1'b0; // last_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // [15:0] abs_mean, [47:16] square_mean,
                                           // [63:48] duty_fraction, [79:64] longest_run_fraction
    logic                  m_tuser;        // [0] overflow
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rf_envelope_statistics #(
        .MAX_SAMPLES (PULSE_LIMIT)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // samples waiting to be offered, and pulse results waiting to be seen
    sample_t      sample_queue[$];
    pulse_stats_t stats_due[$];
    sample_t      next_sample;

    // idle percentages for both sides, and the long receiver hold-off
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic rx_hold_req = 1'b0;
    logic rx_hold = 1'b0;

    // bookkeeping
    int error_count = 0;
    int mismatch_count = 0;
    int pulses_checked = 0;
    int samples_sent = 0;
    int overflow_pulses = 0;
    int threshold_settings = 1;

    // predictor state: mirrors the block's accumulators at their widths
    logic [MAG_W-1:0] thr_copy  = THRESHOLD_RESET;
    logic [27:0]      mag_acc   = '0;
    logic [43:0]      sq_acc    = '0;
    logic [12:0]      above_cnt = '0;
    logic [12:0]      run_len   = '0;
    logic [12:0]      best_run  = '0;
    logic [12:0]      n_samples = '0;
    logic             pulse_ovf = 1'b0;

    // fold one accepted sample into the pulse statistics; on the last sample
    // queue the expected result and start a fresh pulse
    task automatic track_sample(input logic [MAG_W-1:0] mag, input logic last);
        pulse_stats_t r;
        logic [63:0]  longest;
        logic [63:0]  duty;
        logic [63:0]  n;
        // pulse too long: samples past the limit only mark overflow
        if (n_samples < PULSE_LIMIT)
        begin
            n_samples = n_samples + 13'd1;
            mag_acc   = mag_acc + 28'(mag);
            sq_acc    = sq_acc + 44'(mag) * 44'(mag);
            if (mag > thr_copy)
            begin
                above_cnt = above_cnt + 13'd1;
                run_len   = run_len + 13'd1;
            end
            else
            begin
                if (run_len > best_run)
                    best_run = run_len;
                run_len = '0;
            end
        end
        else
            pulse_ovf = 1'b1;
        if (last)
        begin
            n       = 64'(n_samples);
            longest = 64'((run_len > best_run) ? run_len : best_run);
            // duty is floored at the longest run
            duty    = (64'(above_cnt) < longest) ? longest : 64'(above_cnt);
            r.abs_mean             = 16'(64'(mag_acc) / n);
            r.square_mean          = 32'(64'(sq_acc) / n);
            r.duty_fraction        = 16'((duty * FRAC_ONE) / n);
            r.longest_run_fraction = 16'((longest * FRAC_ONE) / n);
            r.overflow             = pulse_ovf;
            stats_due.push_back(r);
            mag_acc   = '0;
            sq_acc    = '0;
            above_cnt = '0;
            run_len   = '0;
            best_run  = '0;
            n_samples = '0;
            pulse_ovf = 1'b0;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            error_count++;
            if (mismatch_count <= SHOW_LIMIT)
                $display("%0t: pulse %0d %s mismatch: expected %0d, got %0d",
                         $realtime, pulses_checked, field, want, got);
        end
    endtask

    // input driver: offers the next queued sample once the current transfer is done
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                next_sample = sample_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_sample.magnitude;
                s_tlast  <= next_sample.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver ready, with random idling and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long hold-off counted here so the sender keeps offering meanwhile
    initial
    begin : rx_hold_off
        wait (rx_hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // predictor: every accepted sample transfer
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            samples_sent++;
            track_sample(s_tdata, s_tlast);
        end
    end

    // monitor: every accepted result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (stats_due.size() == 0)
            begin
                error_count++;
                $display("%0t: result transfer with no pulse pending", $realtime);
            end
            else
            begin
                pulse_stats_t want;
                want = stats_due.pop_front();
                check_field("abs_mean", 32'(want.abs_mean), 32'(m_tdata[15:0]));
                check_field("square_mean", want.square_mean, m_tdata[47:16]);
                check_field("duty_fraction", 32'(want.duty_fraction), 32'(m_tdata[63:48]));
                check_field("longest_run_fraction", 32'(want.longest_run_fraction),
                            32'(m_tdata[79:64]));
                check_field("overflow", 32'(want.overflow), 32'(m_tuser));
                if (want.overflow)
                    overflow_pulses++;
                pulses_checked++;
            end
        end
    end

    // end of run guard
    initial
    begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic sample_t make_sample(input int mag, input bit last);
        sample_t s;
        s.magnitude = MAG_W'(mag);
        s.last      = last;
        return s;
    endfunction

    // magnitude with a bias toward one side of the threshold, so runs form
    function automatic int pick_magnitude(input bit above);
        int t;
        case ($urandom_range(7))
            0: return 0;
            1: return 65535;
            2:
            begin
                // right around the threshold, strict compare
                t = int'(thr_copy) + int'($urandom_range(4)) - 2;
                if (t < 0)
                    t = 0;
                if (t > 65535)
                    t = 65535;
                return t;
            end
            3: return int'($urandom_range(65535));
            default:
            begin
                if (above && thr_copy != 16'hFFFF)
                    return int'($urandom_range(65535, int'(thr_copy) + 1));
                return int'($urandom_range(int'(thr_copy), 0));
            end
        endcase
    endfunction

    // one pulse of the given length, random content
    task automatic add_pulse(input int len);
        bit above;
        above = $urandom_range(1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(3) == 0)
                above = !above;
            sample_queue.push_back(make_sample(pick_magnitude(above), i == len - 1));
        end
    endtask

    // random pulses, mostly short, a few longer ones
    task automatic add_random_pulses(input int item_budget, input int max_len);
        int added;
        int len;
        added = 0;
        while (added < item_budget)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(64, 17);
            else
                len = $urandom_range(max_len, 1);
            add_pulse(len);
            added += len;
        end
    endtask

    // let everything queued go through and every result come back
    task automatic drain;
        while (sample_queue.size() != 0 || s_tvalid || stats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read back the threshold and compare with the predictor's copy
    task automatic apb_check_threshold;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THRESHOLD_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DATA_W'(thr_copy))
        begin
            error_count++;
            $display("%0t: threshold readback expected %0d, got %0d",
                     $realtime, thr_copy, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new threshold, only with the block idle
    task automatic set_threshold(input logic [MAG_W-1:0] value);
        drain();
        // random junk in the upper bits is dropped by the block
        apb_write(THRESHOLD_ADDR, {16'($urandom), value});
        thr_copy = value;
        threshold_settings++;
        apb_check_threshold();
    endtask

    initial
    begin : main
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset threshold, sender idles 6 percent, receiver 48
        tx_idle_pct = 6;
        rx_idle_pct = 48;
        apb_check_threshold();
        // single-sample pulses at both extremes
        sample_queue.push_back(make_sample(0, 1'b1));
        sample_queue.push_back(make_sample(65535, 1'b1));
        // strict compare at the threshold, run still open on the last sample
        sample_queue.push_back(make_sample(7327, 1'b0));
        sample_queue.push_back(make_sample(7328, 1'b0));
        sample_queue.push_back(make_sample(7327, 1'b0));
        sample_queue.push_back(make_sample(7328, 1'b0));
        sample_queue.push_back(make_sample(7328, 1'b1));
        // longest run closed before the end
        sample_queue.push_back(make_sample(65535, 1'b0));
        sample_queue.push_back(make_sample(65535, 1'b0));
        sample_queue.push_back(make_sample(65535, 1'b0));
        sample_queue.push_back(make_sample(0, 1'b0));
        sample_queue.push_back(make_sample(65535, 1'b1));
        // small values, uneven division
        sample_queue.push_back(make_sample(1, 1'b0));
        sample_queue.push_back(make_sample(2, 1'b0));
        sample_queue.push_back(make_sample(3, 1'b1));
        add_random_pulses(250, 16);

        // threshold at zero: any nonzero sample is above
        set_threshold(16'd0);
        sample_queue.push_back(make_sample(0, 1'b0));
        sample_queue.push_back(make_sample(1, 1'b0));
        sample_queue.push_back(make_sample(0, 1'b1));
        add_random_pulses(250, 16);

        // threshold at full scale: nothing is above; roles of idling swapped
        set_threshold(16'hFFFF);
        tx_idle_pct = 48;
        rx_idle_pct = 6;
        sample_queue.push_back(make_sample(65535, 1'b1));
        add_random_pulses(250, 16);

        set_threshold(16'($urandom));
        add_random_pulses(250, 16);

        // no idling from here on
        set_threshold(16'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // receiver holds off while short pulses keep coming, input must stall
        rx_hold_req = 1'b1;
        add_random_pulses(100, 3);
        drain();
        // back to full speed on both sides after the stall
        add_random_pulses(150, 16);

        set_threshold(THRESHOLD_RESET);
        add_random_pulses(250, 16);
        drain();

        if (stats_due.size() != 0)
        begin
            error_count++;
            $display("%0d pulse results never arrived", stats_due.size());
        end
        $display("covered %0d samples in %0d pulses (%0d with overflow), %0d threshold settings",
                 samples_sent, pulses_checked, overflow_pulses, threshold_settings);
        $display("field mismatches: %0d, other errors: %0d",
                 mismatch_count, error_count - mismatch_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/rfes_pkg.sv
sv/rfes_front.sv
sv/rfes_queue.sv
sv/rfes_divider.sv
sv/rf_envelope_statistics.sv
test/testbench.sv
